[rtl/core/ewd_pkg.sv]
// Shared types, codes and lookup functions for the e-paper drive encoder.
// No dependencies; used by ewd_encode and epaper_waveform_drive_encoder_core.
package ewd_pkg;

  typedef enum logic [2:0] {
    OP_MONO   = 3'd0,
    OP_SETTLE = 3'd1,
    OP_GRAY   = 3'd2,
    OP_DIFF   = 3'd3,
    OP_STORE  = 3'd4
  } ewd_op_e;

  // Two-bit source drive pairs
  localparam logic [1:0] PairBlack = 2'd1;
  localparam logic [1:0] PairWhite = 2'd2;
  localparam logic [1:0] PairNone  = 2'd3;

  localparam int unsigned WaveCols = 9;

  // Item held between the memory read and the output register
  typedef struct packed {
    ewd_op_e     op;
    logic [15:0] pix;
    logic [3:0]  phase;
    logic        gray_ok;   // phase inside the configured column count
    logic        in_range;  // address inside the frame
  } ewd_stage_t;

  // Waveform ROM: row is the 3-bit gray level, column the phase.
  function automatic logic [1:0] wave_rom(input logic [2:0] lvl, input logic [3:0] ph);
    logic [17:0] row;
    row = '0;
    case (lvl)
      3'd0:    row = {2'd0, 2'd1, 2'd1, 2'd1, 2'd1, 2'd0, 2'd0, 2'd0, 2'd0};
      3'd1:    row = {2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd1, 2'd0, 2'd0, 2'd0};
      3'd2:    row = {2'd0, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd1, 2'd1, 2'd1};
      3'd3:    row = {2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd1, 2'd1, 2'd1};
      3'd4:    row = {2'd0, 2'd0, 2'd1, 2'd2, 2'd2, 2'd1, 2'd1, 2'd1, 2'd1};
      3'd5:    row = {2'd0, 2'd0, 2'd1, 2'd2, 2'd2, 2'd1, 2'd1, 2'd1, 2'd0};
      3'd6:    row = {2'd0, 2'd0, 2'd2, 2'd1, 2'd1, 2'd0, 2'd0, 2'd0, 2'd0};
      3'd7:    row = {2'd0, 2'd0, 2'd2, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0};
      default: row = '0;
    endcase
    if (ph < 4'(WaveCols)) begin
      return row[{ph, 1'b0} +: 2];
    end
    return 2'd0;
  endfunction

  // Nibble bit i picks pair i: set_pair when the bit is set, clr_pair otherwise.
  function automatic logic [7:0] nib_code(input logic [3:0] nib, input logic [1:0] set_pair,
                                          input logic [1:0] clr_pair);
    logic [7:0] r;
    r = '0;
    for (int i = 0; i < 4; i++) begin
      r[2*i +: 2] = nib[i] ? set_pair : clr_pair;
    end
    return r;
  endfunction

  function automatic logic [15:0] byte_code(input logic [7:0] b, input logic [1:0] set_pair,
                                            input logic [1:0] clr_pair);
    return {nib_code(b[7:4], set_pair, clr_pair), nib_code(b[3:0], set_pair, clr_pair)};
  endfunction

  function automatic logic [3:0] gray_code(input logic [7:0] b, input logic [3:0] ph);
    return {wave_rom(b[2:0], ph), wave_rom(b[6:4], ph)};
  endfunction

endpackage

[rtl/core/epaper_waveform_drive_encoder_core.sv]
// Top level of the e-paper drive encoder: previous-frame memory, two-stage pipeline.
// Depends on ewd_pkg and ewd_encode.
//
// Takes one word per clock while in_stall_o is low and returns one drive word per
// word, in order. The previous-frame memory is read for each accepted diff and
// written for each accepted in-range store, at the acceptance edge, which keeps the
// rate of one word per clock; a store is in the memory before any later partial diff
// reads it, so back-to-back store and diff at one address see the new byte. A stage
// register and an output register let a new word enter while a result waits. Partial
// diff of an in-range byte never stored returns an undefined code.
module epaper_waveform_drive_encoder_core #(
  parameter int unsigned FRAME_BYTES = 131072,
  parameter int unsigned GRAY_PHASES = 9
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  operation_i,
  input  logic [16:0] byte_address_i,
  input  logic [15:0] pixel_data_i,
  input  logic [3:0]  phase_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] drive_word_o
);
  import ewd_pkg::*;

  localparam int unsigned AddrW = $clog2(FRAME_BYTES);
  localparam int unsigned ExtW  = (AddrW > 17) ? AddrW : 17;

  logic             in_accept;
  logic             s1_adv;
  logic             out_free;
  ewd_op_e          in_op;
  logic [ExtW-1:0]  addr_ext;
  logic [AddrW-1:0] mem_idx;
  logic             addr_ok;
  logic             mem_rd;
  logic             mem_wr;

  logic [7:0]       mem_q [FRAME_BYTES];
  logic [7:0]       rd_q;

  logic             s1_valid_q, s1_valid_d;
  ewd_stage_t       s1_q, s1_d;
  logic             out_valid_q, out_valid_d;
  logic [15:0]      drive_q;
  logic [15:0]      drive_d;

  assign in_op    = ewd_op_e'(operation_i);
  assign addr_ext = ExtW'(byte_address_i);
  assign mem_idx  = addr_ext[AddrW-1:0];
  assign addr_ok  = 32'(byte_address_i) < 32'(FRAME_BYTES);

  // Output register frees when empty or being taken; stage follows it.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign mem_rd = in_accept && (in_op == OP_DIFF);
  assign mem_wr = in_accept && (in_op == OP_STORE) && addr_ok;

  // Read data holds while the stage is stalled since no new read is issued.
  always_ff @(posedge clk_i) begin
    if (mem_wr) begin
      mem_q[mem_idx] <= pixel_data_i[7:0];
    end
    if (mem_rd) begin
      rd_q <= mem_q[mem_idx];
    end
  end

  always_comb begin
    s1_d.op       = in_op;
    s1_d.pix      = pixel_data_i;
    s1_d.phase    = phase_i;
    s1_d.gray_ok  = 5'(phase_i) < 5'(GRAY_PHASES);
    s1_d.in_range = addr_ok;
    s1_valid_d    = in_accept || (s1_valid_q && !s1_adv);
    out_valid_d   = s1_adv || (out_valid_q && out_stall_i);
  end

  ewd_encode u_encode (
    .stage_i      (s1_q),
    .old_byte_i   (rd_q),
    .drive_word_o (drive_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q <= s1_d;
    end
    if (s1_adv) begin
      drive_q <= drive_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign drive_word_o = drive_q;

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled while pipeline has room");

  a_rd_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv && (s1_q.op == OP_DIFF)) |=> $stable(rd_q))
    else $error("read data changed under a stalled stage");

  a_store_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && (s1_q.op == OP_STORE)) |=> (out_valid_q && (drive_q == 16'h0000)))
    else $error("store produced a nonzero drive word");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_stall_i && !s1_valid_q) |=> !out_valid_q)
    else $error("output valid without a word behind it");

  a_no_rw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_rd && mem_wr))
    else $error("memory read and write in one cycle");

endmodule

[rtl/core/ewd_encode.sv]
// Drive code encoder: turns one staged item and its previous-frame byte into a drive word.
// Depends on ewd_pkg.
module ewd_encode (
  input  ewd_pkg::ewd_stage_t stage_i,
  input  logic [7:0]          old_byte_i,
  output logic [15:0]         drive_word_o
);
  import ewd_pkg::*;

  logic [7:0] old_b;
  logic [7:0] new_b;
  logic [7:0] white_mask;
  logic [7:0] black_mask;

  assign new_b      = stage_i.pix[7:0];
  assign old_b      = stage_i.in_range ? old_byte_i : 8'h00;
  assign white_mask = old_b & ~new_b;
  assign black_mask = ~old_b & new_b;

  always_comb begin
    drive_word_o = '0;
    case (stage_i.op)
      OP_MONO:   drive_word_o = byte_code(new_b, PairBlack, PairNone);
      OP_SETTLE: drive_word_o = byte_code(new_b, PairBlack, PairWhite);
      OP_GRAY: begin
        if (stage_i.gray_ok) begin
          drive_word_o = {8'h00, gray_code(stage_i.pix[15:8], stage_i.phase),
                          gray_code(new_b, stage_i.phase)};
        end
      end
      OP_DIFF:   drive_word_o = byte_code(white_mask, PairWhite, PairNone)
                              & byte_code(black_mask, PairBlack, PairNone);
      OP_STORE:  drive_word_o = '0;
      default:   drive_word_o = '0;
    endcase
  end

endmodule

[tb/epaper_waveform_drive_encoder_core_tb.sv]
// Testbench for epaper_waveform_drive_encoder_core: directed and random words through the
// valid/stall ports, each drive word checked against an in-bench encoder and frame shadow.
// Depends on ewd_pkg and the encoder RTL.
`timescale 1ns / 1ps

module epaper_waveform_drive_encoder_core_tb;
  import ewd_pkg::*;

  localparam int unsigned FrameBytes   = 131072;
  localparam int unsigned GrayCols     = 9;
  localparam logic [2:0]  OpFirstSpare = 3'd5;
  localparam logic [2:0]  OpLastSpare  = 3'd7;
  localparam int unsigned StallLimit   = 4000;
  localparam int unsigned TailCycles   = 8;
  localparam int unsigned MaxReports   = 10;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [2:0]  operation_i;
  logic [16:0] byte_address_i;
  logic [15:0] pixel_data_i;
  logic [3:0]  phase_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] drive_word_o;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned mismatches    = 0;
  int unsigned idle_cycles   = 0;
  int unsigned words_sent    = 0;
  int unsigned stores_sent   = 0;
  int unsigned diffs_sent    = 0;
  int unsigned words_checked = 0;

  logic [15:0] drive_expect_q[$];
  logic [15:0] drive_head;
  logic [7:0]  frame_shadow[logic [16:0]];
  logic [16:0] shadow_addrs[$];

  epaper_waveform_drive_encoder_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .byte_address_i (byte_address_i),
    .pixel_data_i   (pixel_data_i),
    .phase_i        (phase_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .drive_word_o   (drive_word_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Waveform level of one gray pixel at one phase; columns past the table read zero.
  function automatic logic [1:0] wave_level(input logic [2:0] lvl, input logic [3:0] ph);
    logic [17:0] row;  // phase 0 in the top pair
    case (lvl)
      3'd0:    row = {2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd1, 2'd0};
      3'd1:    row = {2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd1, 2'd0, 2'd0};
      3'd2:    row = {2'd1, 2'd1, 2'd1, 2'd1, 2'd0, 2'd2, 2'd1, 2'd0, 2'd0};
      3'd3:    row = {2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd1, 2'd1, 2'd0, 2'd0};
      3'd4:    row = {2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd1, 2'd0, 2'd0};
      3'd5:    row = {2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd1, 2'd0, 2'd0};
      3'd6:    row = {2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd0, 2'd0};
      3'd7:    row = {2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd2, 2'd0, 2'd0};
      default: row = '0;
    endcase
    if (ph >= GrayCols) begin
      return 2'd0;
    end
    return row[17 - 2 * ph -: 2];
  endfunction

  // Pixel bit i drives pair i of the word.
  function automatic logic [15:0] pair_map(input logic [7:0] b, input logic [1:0] on_pair,
                                           input logic [1:0] off_pair);
    logic [15:0] r;
    int          i;
    for (i = 0; i < 8; i++) begin
      r[2*i +: 2] = b[i] ? on_pair : off_pair;
    end
    return r;
  endfunction

  function automatic logic [15:0] predict_drive(input logic [2:0] op, input logic [16:0] addr,
                                                input logic [15:0] pix, input logic [3:0] ph);
    logic [7:0] old_b;
    logic [7:0] lo;
    logic [3:0] g_hi;
    logic [3:0] g_lo;
    lo = pix[7:0];
    case (op)
      OP_MONO:   return pair_map(lo, PairBlack, PairNone);
      OP_SETTLE: return pair_map(lo, PairBlack, PairWhite);
      OP_GRAY: begin
        g_hi = {wave_level(pix[10:8], ph), wave_level(pix[14:12], ph)};
        g_lo = {wave_level(pix[2:0], ph), wave_level(pix[6:4], ph)};
        return {8'h00, g_hi, g_lo};
      end
      OP_DIFF: begin
        old_b = frame_shadow[addr];
        // white where a pixel clears, black where it sets, no drive elsewhere
        return pair_map(old_b & ~lo, PairWhite, PairNone) &
               pair_map(~old_b & lo, PairBlack, PairNone);
      end
      default: return 16'h0000;
    endcase
  endfunction

  task automatic send_word(input logic [2:0] op, input logic [16:0] addr,
                           input logic [15:0] pix, input logic [3:0] ph);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    operation_i    <= op;
    byte_address_i <= addr;
    pixel_data_i   <= pix;
    phase_i        <= ph;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    drive_expect_q.push_back(predict_drive(op, addr, pix, ph));
    if (op == OP_STORE) begin
      if (!frame_shadow.exists(addr)) begin
        shadow_addrs.push_back(addr);
      end
      frame_shadow[addr] = pix[7:0];
      stores_sent++;
    end
    if (op == OP_DIFF) begin
      diffs_sent++;
    end
    words_sent++;
  endtask

  // Drop valid and hold until every outstanding drive word has come back.
  task automatic wait_all_results;
    in_valid_i <= 1'b0;
    while (drive_expect_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic test_mono_codes;
    send_word(OP_MONO, 17'd0, 16'h0000, 4'd0);
    send_word(OP_MONO, 17'd0, 16'h00FF, 4'd0);
    send_word(OP_MONO, 17'h1FFFF, 16'hFFAA, 4'hF);
    send_word(OP_SETTLE, 17'd0, 16'h0055, 4'd0);
    send_word(OP_SETTLE, 17'h1FFFF, 16'hFF00, 4'hF);
  endtask

  task automatic test_gray_phases;
    send_word(OP_GRAY, 17'd0, 16'h7777, 4'd0);
    send_word(OP_GRAY, 17'd0, 16'h7070, 4'd6);
    send_word(OP_GRAY, 17'd0, 16'h3625, 4'd8);
    send_word(OP_GRAY, 17'd0, 16'hC1DA, 4'd4);
    send_word(OP_GRAY, 17'd0, 16'hFFFF, 4'd9);
    send_word(OP_GRAY, 17'd0, 16'hFFFF, 4'hF);
  endtask

  task automatic test_store_diff;
    send_word(OP_STORE, 17'd0, 16'h00AA, 4'd0);
    send_word(OP_DIFF, 17'd0, 16'h0055, 4'd0);
    send_word(OP_STORE, 17'(FrameBytes - 1), 16'hFFFF, 4'hF);
    send_word(OP_DIFF, 17'(FrameBytes - 1), 16'h00FF, 4'd0);
    send_word(OP_DIFF, 17'(FrameBytes - 1), 16'hFF00, 4'd0);
    send_word(OP_STORE, 17'd0, 16'h000F, 4'd0);
    send_word(OP_DIFF, 17'd0, 16'h00F0, 4'd0);
  endtask

  task automatic test_spare_ops;
    int op;
    for (op = OpFirstSpare; op <= OpLastSpare; op++) begin
      send_word(3'(op), 17'h1FFFF, 16'hFFFF, 4'hF);
    end
  endtask

  // Mostly store/diff pairs and lookups on random data; diffs only read stored bytes.
  task automatic test_random_mix(input int unsigned n_words);
    int unsigned sel;
    int unsigned done;
    logic [16:0] addr;
    logic [15:0] pix;
    logic [3:0]  ph;
    done = 0;
    while (done < n_words) begin
      sel  = $urandom_range(99);
      pix  = 16'($urandom);
      addr = 17'($urandom);
      ph   = 4'($urandom_range(GrayCols - 1));
      if (sel < 25) begin
        if (shadow_addrs.size() != 0 && $urandom_range(3) == 0) begin
          addr = shadow_addrs[$urandom_range(shadow_addrs.size() - 1)];
        end else if ($urandom_range(15) == 0) begin
          addr = $urandom_range(1) ? 17'(FrameBytes - 1) : 17'd0;
        end
        send_word(OP_STORE, addr, pix, ph);
        done++;
        if ($urandom_range(1) == 1) begin
          send_word(OP_DIFF, addr, 16'($urandom), ph);
          done++;
        end
      end else if (sel < 45 && shadow_addrs.size() != 0) begin
        addr = shadow_addrs[$urandom_range(shadow_addrs.size() - 1)];
        send_word(OP_DIFF, addr, pix, ph);
        done++;
      end else if (sel < 60) begin
        send_word(OP_MONO, addr, pix, ph);
        done++;
      end else if (sel < 72) begin
        send_word(OP_SETTLE, addr, pix, ph);
        done++;
      end else if (sel < 95) begin
        if ($urandom_range(7) == 0) begin
          ph = 4'($urandom_range(15, GrayCols));
        end
        send_word(OP_GRAY, addr, pix, ph);
        done++;
      end else begin
        send_word(3'($urandom_range(OpLastSpare, OpFirstSpare)), addr, pix, 4'($urandom));
        done++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      words_checked++;
      if (drive_expect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports) begin
          $display("unexpected drive word %h at %0t", drive_word_o, $realtime);
        end
      end else begin
        drive_head = drive_expect_q.pop_front();
        if (drive_word_o !== drive_head) begin
          mismatches++;
          if (mismatches <= MaxReports) begin
            $display("drive_word mismatch at %0t: expected %h, got %h",
                     $realtime, drive_head, drive_word_o);
          end
        end
      end
    end
  end

  // End the run when no word moves on either side for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("watchdog: no word moved for %0d cycles", idle_cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    operation_i    <= OP_MONO;
    byte_address_i <= '0;
    pixel_data_i   <= '0;
    phase_i        <= '0;
    send_idle_pct  = 14;
    recv_idle_pct  = 75;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_mono_codes();
    test_gray_phases();
    test_store_diff();
    test_spare_ops();
    test_random_mix(520);
    wait_all_results();

    send_idle_pct = 75;
    recv_idle_pct = 14;
    test_random_mix(520);
    wait_all_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_mix(510);
    wait_all_results();
    repeat (TailCycles) @(posedge clk_i);

    $display("sent %0d words (%0d stores, %0d partial diffs), checked %0d drive words",
             words_sent, stores_sent, diffs_sent, words_checked);
    $display("across three sender/receiver stall mixes, %0d mismatches", mismatches);
    if (mismatches == 0 && drive_expect_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
